@@ hw/rtl/fehs_pkg.sv @@
// ----------------------------------------------------------------------------
// fehs_pkg
// Shared widths, register codes, item types and helpers of the frame energy
// hysteresis segmenter.
// ----------------------------------------------------------------------------
package fehs_pkg;

    localparam int MAX_SAMPLES = 65536;
    localparam int MAX_FRAME   = 4096;

    localparam int SAMPLE_W  = 16;
    localparam int CFG_LEN_W = 13;
    localparam int THR_W     = 32;
    localparam int POS_W     = 16;
    localparam int COUNT_W   = 17;

    localparam int IDX_W  = $clog2(MAX_SAMPLES + 1);
    localparam int FILL_W = $clog2(MAX_FRAME + 1);
    localparam int LEN_W  = (FILL_W > CFG_LEN_W) ? FILL_W : CFG_LEN_W;
    localparam int SQ_W   = 2 * SAMPLE_W - 1;
    localparam int SUM_W  = SQ_W + $clog2(MAX_FRAME);
    localparam int LVL_W  = THR_W + FILL_W;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = THR_W;
    localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_LENGTH = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ONSET_THR    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_OFFSET_THR   = 2'd2;

    localparam logic [CFG_LEN_W-1:0] RESET_FRAME_LENGTH = 13'd441;
    localparam logic [THR_W-1:0]     RESET_ONSET_THR    = 32'd107374;
    localparam logic [THR_W-1:0]     RESET_OFFSET_THR   = 32'd26844;

    localparam int FQ_DEPTH = 4;
    localparam int FQ_PTR_W = $clog2(FQ_DEPTH);
    localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);
    localparam int RQ_DEPTH = 4;
    localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } t_in_item;

    typedef struct packed {
        logic               is_offset;
        logic [POS_W-1:0]   position;
        logic [COUNT_W-1:0] boundary_count;
    } t_out_item;

    typedef struct packed {
        logic              last;
        logic [FILL_W-1:0] count;
        logic [POS_W-1:0]  start;
        logic [SUM_W-1:0]  sum;
    } t_frame_rec;

    typedef struct packed {
        logic [FQ_CNT_W-1:0] count;
        logic                empty;
    } t_fq_status;

    function automatic logic [FILL_W-1:0] eff_length(input logic [CFG_LEN_W-1:0] len);
        logic [LEN_W-1:0] wide;
        wide = LEN_W'(len);
        if (wide == '0) begin
            wide = LEN_W'(1);
        end else if (wide > LEN_W'(MAX_FRAME)) begin
            wide = LEN_W'(MAX_FRAME);
        end
        return FILL_W'(wide);
    endfunction

endpackage

@@ hw/rtl/fehs_front.sv @@
// ----------------------------------------------------------------------------
// fehs_front
// Takes input items, squares each sample and accumulates frame energy; emits
// one frame record per closed frame or end of buffer.
// ----------------------------------------------------------------------------
module fehs_front import fehs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  t_in_item             i_item,
    input  t_fq_status           i_fq_status,
    input  logic [CFG_LEN_W-1:0] i_frame_length,
    output logic                 o_full,
    output logic                 o_rec_valid,
    output t_frame_rec           o_rec
);

    logic                r_a_valid;
    t_in_item            r_a_item;
    logic                r_b_valid;
    logic [SQ_W-1:0]     r_b_sq;
    logic                r_b_last;
    logic [SUM_W-1:0]    r_sum;
    logic [FILL_W-1:0]   r_fill;
    logic [POS_W-1:0]    r_start;
    logic [IDX_W-1:0]    r_idx;

    logic [FQ_CNT_W:0]     w_level;
    logic                  w_accept;
    logic [SAMPLE_W-1:0]   w_mag;
    logic [2*SAMPLE_W-1:0] w_prod;
    logic                  w_take;
    logic [FILL_W-1:0]     w_fill1;
    logic [SUM_W-1:0]      w_sum1;
    logic [POS_W-1:0]      w_start1;
    logic [IDX_W-1:0]      w_idx1;
    logic                  w_close;

    assign w_level = (FQ_CNT_W+1)'(i_fq_status.count) + (FQ_CNT_W+1)'(r_a_valid)
                   + (FQ_CNT_W+1)'(r_b_valid);
    assign o_full   = w_level >= (FQ_CNT_W+1)'(FQ_DEPTH);
    assign w_accept = i_push && !o_full;

    assign w_mag  = r_a_item.sample[SAMPLE_W-1] ? SAMPLE_W'(-r_a_item.sample)
                                                : SAMPLE_W'(r_a_item.sample);
    assign w_prod = w_mag * w_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= w_accept;
            r_b_valid <= r_a_valid;
        end
        if (w_accept) begin
            r_a_item <= i_item;
        end
        r_b_sq   <= w_prod[SQ_W-1:0];
        r_b_last <= r_a_item.last;
    end

    always_comb begin
        w_take   = r_idx < IDX_W'(MAX_SAMPLES);
        w_fill1  = w_take ? r_fill + FILL_W'(1) : r_fill;
        w_sum1   = w_take ? r_sum + SUM_W'(r_b_sq) : r_sum;
        w_start1 = (w_take && r_fill == '0) ? POS_W'(r_idx) : r_start;
        w_idx1   = w_take ? r_idx + IDX_W'(1) : r_idx;
        w_close  = r_b_valid && ((w_take && w_fill1 >= eff_length(i_frame_length))
                              || (r_b_last && w_fill1 != '0));
        o_rec_valid = r_b_valid && (w_close || r_b_last);
        o_rec.last  = r_b_last;
        o_rec.count = w_close ? w_fill1 : '0;
        o_rec.start = w_start1;
        o_rec.sum   = w_sum1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_fill  <= '0;
            r_start <= '0;
            r_idx   <= '0;
        end else if (r_b_valid) begin
            if (r_b_last) begin
                r_sum   <= '0;
                r_fill  <= '0;
                r_start <= '0;
                r_idx   <= '0;
            end else if (w_close) begin
                r_sum   <= '0;
                r_fill  <= '0;
                r_start <= w_start1;
                r_idx   <= w_idx1;
            end else begin
                r_sum   <= w_sum1;
                r_fill  <= w_fill1;
                r_start <= w_start1;
                r_idx   <= w_idx1;
            end
        end
    end

endmodule

@@ hw/rtl/fehs_frame_queue.sv @@
// ----------------------------------------------------------------------------
// fehs_frame_queue
// Short queue of frame records between the accumulating front and the
// deciding back.
// ----------------------------------------------------------------------------
module fehs_frame_queue import fehs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_wr,
    input  t_frame_rec i_rec,
    input  logic       i_rd,
    output t_frame_rec o_head,
    output t_fq_status o_status
);

    t_frame_rec          r_mem [FQ_DEPTH];
    logic [FQ_PTR_W-1:0] r_wr_ptr;
    logic [FQ_PTR_W-1:0] r_rd_ptr;
    logic [FQ_CNT_W-1:0] r_cnt;
    logic [FQ_CNT_W-1:0] n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_wr && !i_rd) begin
            n_cnt = r_cnt + FQ_CNT_W'(1);
        end else if (!i_wr && i_rd) begin
            n_cnt = r_cnt - FQ_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + FQ_PTR_W'(1);
            end
            if (i_rd) begin
                r_rd_ptr <= r_rd_ptr + FQ_PTR_W'(1);
            end
            r_cnt <= n_cnt;
        end
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.count = r_cnt;
    assign o_status.empty = (r_cnt == '0);

endmodule

@@ hw/rtl/fehs_back.sv @@
// ----------------------------------------------------------------------------
// fehs_back
// Scales the thresholds by the frame's sample count, applies the onset and
// offset hysteresis and queues boundary items for the consumer.
// ----------------------------------------------------------------------------
module fehs_back import fehs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_fq_status       i_fq_status,
    input  t_frame_rec       i_head,
    output logic             o_fq_pop,
    input  logic [THR_W-1:0] i_onset_thr,
    input  logic [THR_W-1:0] i_offset_thr,
    input  logic             i_res_pop,
    output logic             o_res_empty,
    output t_out_item        o_result
);

    logic               r_m_valid;
    t_frame_rec         r_m_rec;
    logic [LVL_W-1:0]   r_m_on_lvl;
    logic [LVL_W-1:0]   r_m_off_lvl;
    logic               r_in_seg;
    logic [COUNT_W-1:0] r_bnd;

    t_out_item           r_rq_mem [RQ_DEPTH];
    logic [RQ_PTR_W-1:0] r_rq_wr;
    logic [RQ_PTR_W-1:0] r_rq_rd;
    logic [RQ_CNT_W-1:0] r_rq_cnt;

    logic [RQ_CNT_W:0]  w_rq_level;
    logic [LVL_W-1:0]   w_sum;
    logic               w_has;
    logic               w_onset;
    logic               w_offset;
    logic               w_hit;
    logic [COUNT_W-1:0] w_bnd_next;
    logic               w_res_take;

    assign w_rq_level = (RQ_CNT_W+1)'(r_rq_cnt) + (RQ_CNT_W+1)'(r_m_valid);
    assign o_fq_pop   = !i_fq_status.empty && (w_rq_level < (RQ_CNT_W+1)'(RQ_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else begin
            r_m_valid <= o_fq_pop;
        end
        if (o_fq_pop) begin
            r_m_rec     <= i_head;
            r_m_on_lvl  <= LVL_W'(i_onset_thr) * LVL_W'(i_head.count);
            r_m_off_lvl <= LVL_W'(i_offset_thr) * LVL_W'(i_head.count);
        end
    end

    always_comb begin
        w_sum      = LVL_W'(r_m_rec.sum);
        w_has      = r_m_valid && (r_m_rec.count != '0);
        w_onset    = w_has && !r_in_seg && (w_sum > r_m_on_lvl);
        w_offset   = w_has && r_in_seg && (w_sum < r_m_off_lvl);
        w_hit      = w_onset || w_offset;
        w_bnd_next = (r_bnd == COUNT_MAX) ? r_bnd : r_bnd + COUNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_seg <= 1'b0;
            r_bnd    <= '0;
        end else if (r_m_valid) begin
            if (r_m_rec.last) begin
                r_in_seg <= 1'b0;
                r_bnd    <= '0;
            end else if (w_hit) begin
                r_in_seg <= !r_in_seg;
                r_bnd    <= w_bnd_next;
            end
        end
    end

    assign o_res_empty = (r_rq_cnt == '0);
    assign w_res_take  = i_res_pop && !o_res_empty;
    assign o_result    = r_rq_mem[r_rq_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rq_wr  <= '0;
            r_rq_rd  <= '0;
            r_rq_cnt <= '0;
        end else begin
            if (w_hit) begin
                r_rq_wr <= r_rq_wr + RQ_PTR_W'(1);
            end
            if (w_res_take) begin
                r_rq_rd <= r_rq_rd + RQ_PTR_W'(1);
            end
            if (w_hit && !w_res_take) begin
                r_rq_cnt <= r_rq_cnt + RQ_CNT_W'(1);
            end else if (!w_hit && w_res_take) begin
                r_rq_cnt <= r_rq_cnt - RQ_CNT_W'(1);
            end
        end
        if (w_hit) begin
            r_rq_mem[r_rq_wr].is_offset      <= w_offset;
            r_rq_mem[r_rq_wr].position       <= r_m_rec.start;
            r_rq_mem[r_rq_wr].boundary_count <= w_bnd_next;
        end
    end

endmodule

@@ hw/rtl/frame_energy_hysteresis_segmenter.sv @@
// ----------------------------------------------------------------------------
// frame_energy_hysteresis_segmenter
// Energy based voice activity detection with onset and offset hysteresis.
// ----------------------------------------------------------------------------
// Channel   Handshake           Payload      Item accepted when
// input     push / full         i_item       push && !full
// result    empty / pop         o_result     pop && !empty
// config    i_cfg_we            i_cfg_addr   i_cfg_we (no wait)
//                               i_cfg_data
//
// One item is taken per cycle while full is low. After the sample that closes its
// frame, a boundary item passes the input register, square, accumulate into the
// frame queue, threshold multiply and result queue write, one register stage each.
// Reset is synchronous and clears all control state; no clearing pass.
// full rises when the four-entry frame queue plus the two front stages would
// overflow, which happens only while the result side stalls.
// ----------------------------------------------------------------------------
module frame_energy_hysteresis_segmenter import fehs_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  t_in_item              i_item,
    output logic                  empty,
    input  logic                  pop,
    output t_out_item             o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [CFG_LEN_W-1:0] r_frame_length;
    logic [THR_W-1:0]     r_onset_thr;
    logic [THR_W-1:0]     r_offset_thr;

    logic       w_rec_valid;
    t_frame_rec w_rec;
    t_frame_rec w_head;
    t_fq_status w_fq_status;
    logic       w_fq_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_length <= RESET_FRAME_LENGTH;
            r_onset_thr    <= RESET_ONSET_THR;
            r_offset_thr   <= RESET_OFFSET_THR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_FRAME_LENGTH: r_frame_length <= i_cfg_data[CFG_LEN_W-1:0];
                CFG_ONSET_THR:    r_onset_thr    <= i_cfg_data[THR_W-1:0];
                CFG_OFFSET_THR:   r_offset_thr   <= i_cfg_data[THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    fehs_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_item         (i_item),
        .i_fq_status    (w_fq_status),
        .i_frame_length (r_frame_length),
        .o_full         (full),
        .o_rec_valid    (w_rec_valid),
        .o_rec          (w_rec)
    );

    fehs_frame_queue u_frame_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (w_rec_valid),
        .i_rec    (w_rec),
        .i_rd     (w_fq_pop),
        .o_head   (w_head),
        .o_status (w_fq_status)
    );

    fehs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fq_status  (w_fq_status),
        .i_head       (w_head),
        .o_fq_pop     (w_fq_pop),
        .i_onset_thr  (r_onset_thr),
        .i_offset_thr (r_offset_thr),
        .i_res_pop    (pop),
        .o_res_empty  (empty),
        .o_result     (o_result)
    );

endmodule

@@ hw/rtl/fehs_checker.sv @@
// ----------------------------------------------------------------------------
// fehs_checker
// Port level checks of the segmenter, bound to the top level.
// ----------------------------------------------------------------------------
module fehs_checker import fehs_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      full,
    input logic      empty,
    input logic      pop,
    input t_out_item o_result
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("Queues not cleared by reset.");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("Waiting result item changed or vanished.");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.boundary_count != '0))
        else $error("Boundary item with zero count.");

    a_alternation: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ((o_result.is_offset != o_result.boundary_count[0])
                 || (o_result.boundary_count == COUNT_MAX)))
        else $error("Onset and offset items out of alternation.");

endmodule

bind frame_energy_hysteresis_segmenter fehs_checker u_fehs_checker (.*);

@@ test/frame_energy_hysteresis_segmenter_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_energy_hysteresis_segmenter_tb
// Self-checking testbench of the frame energy hysteresis segmenter. A queue of
// sample items, filled phase by phase, feeds a driver with random gaps. Each
// accepted item runs through a local predictor of frame energy, threshold
// hysteresis and boundary counting. A monitor with random stalls checks every
// boundary item field by field. The run covers directed corner cases, a long
// receiver stall, a frame length change in the middle of a frame, and random
// phases.
// ----------------------------------------------------------------------------
module frame_energy_hysteresis_segmenter_tb;
    import fehs_pkg::*;

    typedef enum int unsigned {
        LVL_SILENT,
        LVL_SOFT,
        LVL_RANDOM,
        LVL_PEAK
    } t_level;

    localparam int unsigned LONG_HOLD  = 400;
    localparam int unsigned DRAIN_WAIT = 8;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  push       = 1'b0;
    logic                  full;
    t_in_item              i_item     = '0;
    logic                  empty;
    logic                  pop        = 1'b0;
    t_out_item             o_result;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    t_in_item  pending_q[$];
    t_out_item boundary_q[$];

    logic [CFG_LEN_W-1:0] len_reg    = RESET_FRAME_LENGTH;
    logic [THR_W-1:0]     onset_reg  = RESET_ONSET_THR;
    logic [THR_W-1:0]     offset_reg = RESET_OFFSET_THR;

    bit              seg_active     = 1'b0;
    longint unsigned acc_energy     = 0;
    int unsigned     frame_fill     = 0;
    int unsigned     frame_begin    = 0;
    int unsigned     buf_index      = 0;
    int unsigned     boundary_total = 0;

    int unsigned taken_cnt     = 0;
    int unsigned gapped_cnt    = 0;
    int unsigned gap_left      = 0;
    int unsigned hold_requests = 0;
    int unsigned holds_served  = 0;
    int unsigned hold_left     = 0;
    bit          send_idle_en  = 1'b1;
    bit          recv_idle_en  = 1'b1;

    int unsigned buffers_closed     = 0;
    int unsigned boundaries_checked = 0;
    int unsigned full_cycles        = 0;
    int unsigned error_count        = 0;

    frame_energy_hysteresis_segmenter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .empty      (empty),
        .pop        (pop),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic int unsigned frame_span(input logic [CFG_LEN_W-1:0] len);
        int unsigned n;
        n = len;
        if (n == 0) begin
            n = 1;
        end else if (n > MAX_FRAME) begin
            n = MAX_FRAME;
        end
        return n;
    endfunction

    task automatic close_frame();
        longint unsigned on_lvl;
        longint unsigned off_lvl;
        t_out_item       r;
        bit              hit;
        on_lvl  = onset_reg;
        on_lvl  = on_lvl * frame_fill;
        off_lvl = offset_reg;
        off_lvl = off_lvl * frame_fill;
        hit     = 1'b0;
        r       = '0;
        if (frame_fill != 0) begin
            if (!seg_active && acc_energy > on_lvl) begin
                seg_active  = 1'b1;
                hit         = 1'b1;
                r.is_offset = 1'b0;
            end else if (seg_active && acc_energy < off_lvl) begin
                seg_active  = 1'b0;
                hit         = 1'b1;
                r.is_offset = 1'b1;
            end
            if (hit) begin
                if (boundary_total < COUNT_MAX) begin
                    boundary_total++;
                end
                r.position       = POS_W'(frame_begin);
                r.boundary_count = COUNT_W'(boundary_total);
                boundary_q.insert(boundary_q.size(), r);
            end
        end
        acc_energy = 0;
        frame_fill = 0;
    endtask

    task automatic predict_boundary(input t_in_item it);
        int              s;
        int              mag;
        longint unsigned sq;
        s = $signed(it.sample);
        if (buf_index < MAX_SAMPLES) begin
            mag = (s < 0) ? -s : s;
            sq  = mag;
            sq  = sq * sq;
            if (frame_fill == 0) begin
                frame_begin = buf_index;
            end
            acc_energy += sq;
            frame_fill++;
            buf_index++;
            if (frame_fill >= frame_span(len_reg)) begin
                close_frame();
            end
        end
        if (it.last) begin
            if (frame_fill != 0) begin
                close_frame();
            end
            seg_active     = 1'b0;
            acc_energy     = 0;
            frame_fill     = 0;
            frame_begin    = 0;
            buf_index      = 0;
            boundary_total = 0;
        end
    endtask

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] rand_sample(input t_level lvl);
        int v;
        if (lvl == LVL_SILENT) begin
            v = 0;
        end else if (lvl == LVL_SOFT) begin
            v = int'($urandom_range(0, 600)) - 300;
        end else if (lvl == LVL_RANDOM) begin
            v = int'($urandom_range(0, 65535)) - 32768;
        end else begin
            case ($urandom_range(0, 3))
                0: v = -32768;
                1: v = 32767;
                2: v = -int'($urandom_range(24000, 32767));
                default: v = int'($urandom_range(24000, 32767));
            endcase
        end
        return SAMPLE_W'(v);
    endfunction

    function automatic logic [CFG_LEN_W-1:0] pick_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return CFG_LEN_W'($urandom_range(1, 8));
        end else if (r < 80) begin
            return CFG_LEN_W'($urandom_range(9, 40));
        end else if (r < 95) begin
            return CFG_LEN_W'($urandom_range(41, 200));
        end
        case ($urandom_range(0, 3))
            0: return '0;
            1: return CFG_LEN_W'(MAX_FRAME);
            2: return CFG_LEN_W'(MAX_FRAME + 1);
            default: return '1;
        endcase
    endfunction

    function automatic logic [THR_W-1:0] pick_onset();
        int unsigned r;
        int unsigned a;
        r = $urandom_range(0, 99);
        a = $urandom_range(0, 32767);
        if (r < 10) begin
            return '0;
        end else if (r < 15) begin
            return '1;
        end
        return THR_W'(a * a);
    endfunction

    function automatic logic [THR_W-1:0] pick_offset(input logic [THR_W-1:0] on_thr);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            return '0;
        end else if (r < 15) begin
            return '1;
        end else if (r < 25) begin
            return THR_W'($urandom);
        end
        return on_thr >> $urandom_range(0, 6);
    endfunction

    task automatic add_item(input logic signed [SAMPLE_W-1:0] s, input logic l);
        t_in_item it;
        it.sample = s;
        it.last   = l;
        pending_q.insert(pending_q.size(), it);
    endtask

    task automatic add_buffer(input int unsigned n, input bit close);
        int unsigned span;
        t_level      lvl;
        span = $urandom_range(1, 2 * frame_span(len_reg));
        lvl  = LVL_SILENT;
        for (int unsigned i = 0; i < n; i++) begin
            if (i % span == 0) begin
                lvl = t_level'($urandom_range(0, 3));
            end
            add_item(rand_sample(lvl), close && (i == n - 1));
        end
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        case (addr)
            CFG_FRAME_LENGTH: len_reg    = data[CFG_LEN_W-1:0];
            CFG_ONSET_THR:    onset_reg  = data;
            CFG_OFFSET_THR:   offset_reg = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_length(input logic [CFG_LEN_W-1:0] len);
        write_reg(CFG_FRAME_LENGTH, {(CFG_DATA_W - CFG_LEN_W)'($urandom), len});
    endtask

    task automatic wait_idle();
        while (pending_q.size() != 0) begin
            @(posedge i_clk);
        end
        while (boundary_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && push && !full) begin
            predict_boundary(i_item);
            void'(pending_q.pop_front());
            if (i_item.last) begin
                buffers_closed++;
            end
            taken_cnt++;
        end
    end

    always @(negedge i_clk) begin
        if (taken_cnt != gapped_cnt) begin
            gapped_cnt = taken_cnt;
            gap_left   = send_idle_en ? pick_gap() : 0;
        end
        if (gap_left != 0) begin
            push <= 1'b0;
            gap_left--;
        end else if (pending_q.size() != 0) begin
            push   <= 1'b1;
            i_item <= pending_q[0];
        end else begin
            push <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && full) begin
            full_cycles++;
        end
        if (i_rst_n && pop && !empty) begin
            if (boundary_q.size() == 0) begin
                $error("unexpected boundary item: is_offset %0d position %0d count %0d",
                       o_result.is_offset, o_result.position, o_result.boundary_count);
                error_count++;
            end else begin
                want = boundary_q.pop_front();
                boundaries_checked++;
                if (o_result.is_offset !== want.is_offset) begin
                    $error("is_offset: expected %0d, actual %0d",
                           want.is_offset, o_result.is_offset);
                    error_count++;
                end
                if (o_result.position !== want.position) begin
                    $error("position: expected %0d, actual %0d",
                           want.position, o_result.position);
                    error_count++;
                end
                if (o_result.boundary_count !== want.boundary_count) begin
                    $error("boundary_count: expected %0d, actual %0d",
                           want.boundary_count, o_result.boundary_count);
                    error_count++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left    = LONG_HOLD;
        end
        if (hold_left != 0) begin
            pop <= 1'b0;
            hold_left--;
        end else begin
            pop <= 1'b1;
            if (recv_idle_en) begin
                hold_left = pick_gap();
            end
        end
    end

    initial begin
        int unsigned random_items;
        int unsigned nbuf;
        int unsigned cap;
        int unsigned n;
        t_level      lvl;
        random_items = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings, a partial frame closed by the last flag.
        add_item(16'sh8000, 1'b0);
        add_item(16'sh7FFF, 1'b0);
        add_item(16'sh0000, 1'b1);
        wait_idle();

        // Zero length acts as one; zero onset and all-ones offset toggle freely.
        write_length('0);
        write_reg(CFG_ONSET_THR, '0);
        write_reg(CFG_OFFSET_THR, '1);
        add_item(16'sh0001, 1'b0);
        add_item(16'sh7FFF, 1'b0);
        add_item(16'sh0000, 1'b0);
        add_item(16'shFFFF, 1'b0);
        add_item(16'sh8000, 1'b1);
        wait_idle();

        // Oversized length, thresholds that can never fire.
        write_length('1);
        write_reg(CFG_ONSET_THR, '1);
        write_reg(CFG_OFFSET_THR, '0);
        add_item(16'sh7FFF, 1'b0);
        add_item(16'sh8000, 1'b0);
        add_item(16'sh1234, 1'b1);
        wait_idle();

        // Short frames through onset and offset, a lone last sample.
        write_length(CFG_LEN_W'(2));
        write_reg(CFG_ONSET_THR, THR_W'(1000 * 1000));
        write_reg(CFG_OFFSET_THR, THR_W'(100 * 100));
        add_item(16'sd30000, 1'b0);
        add_item(-16'sd30000, 1'b0);
        add_item(16'sd5, 1'b0);
        add_item(16'sd5, 1'b0);
        add_item(16'sh0000, 1'b0);
        add_item(16'sh8000, 1'b0);
        add_item(16'sh0000, 1'b1);
        add_item(16'sh7FFF, 1'b1);
        wait_idle();

        // The receiver holds off while every sample toggles the segment state.
        write_length(CFG_LEN_W'(1));
        write_reg(CFG_ONSET_THR, THR_W'(10000 * 10000));
        write_reg(CFG_OFFSET_THR, THR_W'(1000 * 1000));
        send_idle_en = 1'b0;
        hold_requests++;
        for (int unsigned i = 0; i < 64; i++) begin
            add_item((i % 2 == 0) ? 16'sd30000 : 16'sd0, i == 63);
        end
        wait_idle();

        // A long frame is cut short by a length change in its middle.
        write_length('1);
        write_reg(CFG_ONSET_THR, THR_W'(6000 * 6000));
        write_reg(CFG_OFFSET_THR, THR_W'(1500 * 1500));
        recv_idle_en = 1'b0;
        lvl = t_level'($urandom_range(1, 3));
        for (int unsigned i = 0; i < 40; i++) begin
            add_item(rand_sample(lvl), 1'b0);
        end
        wait_idle();
        write_length(CFG_LEN_W'(3));
        for (int unsigned i = 0; i < 20; i++) begin
            add_item(rand_sample(t_level'($urandom_range(0, 3))), i == 19);
        end
        wait_idle();

        while (random_items < 780) begin
            send_idle_en = ($urandom_range(0, 3) != 0);
            recv_idle_en = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 2) != 0) begin
                write_length(pick_length());
            end
            if ($urandom_range(0, 2) != 0) begin
                write_reg(CFG_ONSET_THR, pick_onset());
            end
            if ($urandom_range(0, 2) != 0) begin
                write_reg(CFG_OFFSET_THR, pick_offset(onset_reg));
            end
            nbuf = $urandom_range(1, 4);
            cap  = 3 * frame_span(len_reg) + 4;
            if (cap > 150) begin
                cap = 150;
            end
            for (int unsigned b = 0; b < nbuf; b++) begin
                n = $urandom_range(1, cap);
                add_buffer(n, (b < nbuf - 1) || ($urandom_range(0, 2) != 0));
                random_items += n;
            end
            wait_idle();
        end

        add_item(16'sh0000, 1'b1);
        wait_idle();
        repeat (20) @(posedge i_clk);
        if (boundary_q.size() != 0) begin
            $error("%0d boundary items never arrived", boundary_q.size());
            error_count++;
        end
        $display("Covered %0d samples in %0d buffers with %0d boundary items checked.",
                 taken_cnt, buffers_closed, boundaries_checked);
        $display("Input stalled by full for %0d cycles; lengths and thresholds hit extremes.",
                 full_cycles);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #(10_000_000);
        $display("Timeout waiting for the segmenter to drain.");
        $display("Test completed with failures");
        $finish;
    end

endmodule
